// ----- rtl/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, widths and the arctangent table for the distance pipeline
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_ITERATIONS = 24;

    localparam int ROOT_STEPS = 31;

    localparam logic signed [31:0] FULL_TURN_UDEG    = 32'sd360000000;
    localparam logic signed [31:0] HALF_TURN_UDEG    = 32'sd180000000;
    localparam logic signed [31:0] QUARTER_TURN_UDEG = 32'sd90000000;

    localparam logic [31:0] PI_Q32_DIV5    = 32'd2698607541;
    localparam logic [57:0] ROUND_ANGLE    = 58'd144000000;
    localparam logic [29:0] RECIP_DIVISOR  = 30'd1000799917;
    localparam logic [17:0] ANGLE_DIVISOR  = 18'd140625;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30_W       = 34'sd1073741824;
    localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;
    localparam logic signed [63:0] HALF_Q30        = 64'sd536870912;
    localparam logic signed [31:0] PI_Q29          = 32'sd1686629713;
    localparam logic [60:0]        ONE_Q60         = 61'h1000_0000_0000_0000;
    localparam logic [30:0]        METERS_PER_RAD_Q8 = 31'd1630897532;
    localparam logic [61:0]        ROUND_METERS    = 62'h10_0000_0000;

    localparam logic signed [31:0] ATAN_HEAD [10] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575
    };

    function automatic logic signed [31:0] atan_step(input int i);
        logic signed [31:0] r;
        if (i < 10) begin
            r = ATAN_HEAD[4'(i)];
        end else if (i < 30) begin
            r = 32'sd1 <<< (29 - i);
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/gcd_sincos.sv -----
// ----------------------------------------------------------------------------
// gcd_sincos
// Pipelined sine and cosine of an angle in microdegrees, rotation cordic
// ----------------------------------------------------------------------------
module gcd_sincos (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_v,
    input  logic signed [29:0] i_udeg,
    output logic               o_v,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int N = gcd_pkg::CORDIC_ITERATIONS;

    logic [6:0]         r_fv;
    logic signed [31:0] n_d, n_m, n_r, r_r;
    logic signed [31:0] n_abs;
    logic [26:0]        n_a, r_a;
    logic               n_cn;
    logic [6:0]         r_sn, r_cn;
    logic [58:0]        r_prod;
    logic [58:0]        n_sum;
    logic [46:0]        r_m4, r_m5, r_m6, r_m7;
    logic [59:0]        r_pl;
    logic [46:0]        r_ph;
    logic [76:0]        n_q;
    logic [29:0]        r_qe6, r_qe7;
    logic [47:0]        r_t;
    logic [47:0]        n_rem;

    logic               r_v  [0:N];
    logic signed [33:0] r_x  [0:N];
    logic signed [33:0] r_y  [0:N];
    logic signed [31:0] r_z  [0:N];
    logic               r_s  [0:N];
    logic               r_c  [0:N];

    logic signed [33:0] n_xc, n_yc;
    logic               r_ov;
    logic signed [31:0] r_sin, r_cos;

    always_comb begin
        n_d = 32'(i_udeg);
        if (n_d >= gcd_pkg::FULL_TURN_UDEG) begin
            n_m = n_d - gcd_pkg::FULL_TURN_UDEG;
        end else if (n_d <= -gcd_pkg::FULL_TURN_UDEG) begin
            n_m = n_d + gcd_pkg::FULL_TURN_UDEG;
        end else begin
            n_m = n_d;
        end
        if (n_m < 0) begin
            n_r = (n_m > -gcd_pkg::HALF_TURN_UDEG) ? n_m : n_m + gcd_pkg::FULL_TURN_UDEG;
        end else begin
            n_r = (n_m > gcd_pkg::HALF_TURN_UDEG) ? n_m - gcd_pkg::FULL_TURN_UDEG : n_m;
        end
    end

    always_comb begin
        n_abs = (r_r < 0) ? -r_r : r_r;
        n_cn  = n_abs > gcd_pkg::QUARTER_TURN_UDEG;
        n_a   = n_cn ? 27'(gcd_pkg::HALF_TURN_UDEG - n_abs) : 27'(n_abs);
    end

    assign n_sum = r_prod + 59'(gcd_pkg::ROUND_ANGLE);
    assign n_q   = {r_ph, 30'd0} + 77'(r_pl);
    assign n_rem = 48'(r_m7) - r_t;

    // angle conversion: round(a * pi * 2^29 / 180e6) by reciprocal and correction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (i_en) begin
            r_fv <= {r_fv[5:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r    <= n_r;
            r_a    <= n_a;
            r_sn   <= {r_sn[5:1], r_r < 0, 1'b0};
            r_cn   <= {r_cn[5:1], n_cn, 1'b0};
            r_prod <= 59'(r_a) * 59'(gcd_pkg::PI_Q32_DIV5);
            r_m4   <= n_sum[57:11];
            r_pl   <= 60'(r_m4[29:0]) * 60'(gcd_pkg::RECIP_DIVISOR);
            r_ph   <= 47'(r_m4[46:30]) * 47'(gcd_pkg::RECIP_DIVISOR);
            r_m5   <= r_m4;
            r_m6   <= r_m5;
            r_qe6  <= n_q[76:47];
            r_t    <= 48'(r_qe6) * 48'(gcd_pkg::ANGLE_DIVISOR);
            r_qe7  <= r_qe6;
            r_m7   <= r_m6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_fv[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= gcd_pkg::CORDIC_GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= (n_rem >= 48'(gcd_pkg::ANGLE_DIVISOR)) ? 32'(r_qe7) + 32'sd1
                                                             : 32'(r_qe7);
            r_s[0] <= r_sn[6];
            r_c[0] <= r_cn[6];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - gcd_pkg::atan_step(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + gcd_pkg::atan_step(i);
                end
                r_s[i+1] <= r_s[i];
                r_c[i+1] <= r_c[i];
            end
        end
    end

    always_comb begin
        n_xc = r_x[N];
        n_yc = r_y[N];
        if (n_xc > gcd_pkg::ONE_Q30_W) begin
            n_xc = gcd_pkg::ONE_Q30_W;
        end else if (n_xc < -gcd_pkg::ONE_Q30_W) begin
            n_xc = -gcd_pkg::ONE_Q30_W;
        end
        if (n_yc > gcd_pkg::ONE_Q30_W) begin
            n_yc = gcd_pkg::ONE_Q30_W;
        end else if (n_yc < -gcd_pkg::ONE_Q30_W) begin
            n_yc = -gcd_pkg::ONE_Q30_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_s[N] ? 32'(-n_yc) : 32'(n_yc);
            r_cos <= r_c[N] ? 32'(-n_xc) : 32'(n_xc);
        end
    end

    assign o_v   = r_ov;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ----- rtl/gcd_isqrt.sv -----
// ----------------------------------------------------------------------------
// gcd_isqrt
// Pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module gcd_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_v,
    input  logic [60:0] i_n,
    input  logic [31:0] i_tag,
    output logic        o_v,
    output logic [30:0] o_root,
    output logic [31:0] o_tag
);

    localparam int S = gcd_pkg::ROOT_STEPS;

    logic        r_v   [1:S];
    logic [60:0] r_n   [1:S];
    logic [60:0] r_r   [1:S];
    logic [31:0] r_tag [1:S];

    for (genvar k = 0; k < S; k++) begin : g_bit
        logic        w_v;
        logic [60:0] w_n;
        logic [60:0] w_r;
        logic [31:0] w_tag;
        logic [61:0] n_try;
        logic [61:0] n_bit;

        if (k == 0) begin : g_first
            assign w_v   = i_v;
            assign w_n   = i_n;
            assign w_r   = '0;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_v   = r_v[k];
            assign w_n   = r_n[k];
            assign w_r   = r_r[k];
            assign w_tag = r_tag[k];
        end

        assign n_bit = 62'd1 << (2 * (S - 1 - k));
        assign n_try = {1'b0, w_r} + n_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, w_n} >= n_try) begin
                    r_n[k+1] <= w_n - n_try[60:0];
                    r_r[k+1] <= (w_r >> 1) + n_bit[60:0];
                end else begin
                    r_n[k+1] <= w_n;
                    r_r[k+1] <= w_r >> 1;
                end
                r_tag[k+1] <= w_tag;
            end
        end
    end

    assign o_v    = r_v[S];
    assign o_root = r_r[S][30:0];
    assign o_tag  = r_tag[S];

endmodule

// ----- rtl/gcd_acos.sv -----
// ----------------------------------------------------------------------------
// gcd_acos
// Pipelined vectoring cordic giving the arc angle from cosine and sine parts
// ----------------------------------------------------------------------------
module gcd_acos (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_v,
    input  logic [30:0] i_abs_cos,
    input  logic [30:0] i_root,
    input  logic        i_neg,
    output logic        o_v,
    output logic [30:0] o_angle
);

    localparam int N = gcd_pkg::CORDIC_ITERATIONS;

    logic               r_v [1:N];
    logic signed [33:0] r_x [1:N];
    logic signed [33:0] r_y [1:N];
    logic signed [31:0] r_z [1:N];
    logic               r_g [1:N];

    logic signed [31:0] n_z;
    logic               r_ov;
    logic [30:0]        r_angle;

    for (genvar i = 0; i < N; i++) begin : g_vec
        logic               w_v;
        logic signed [33:0] w_x;
        logic signed [33:0] w_y;
        logic signed [31:0] w_z;
        logic               w_g;

        if (i == 0) begin : g_first
            assign w_v = i_v;
            assign w_x = 34'(i_abs_cos);
            assign w_y = 34'(i_root);
            assign w_z = '0;
            assign w_g = i_neg;
        end else begin : g_next
            assign w_v = r_v[i];
            assign w_x = r_x[i];
            assign w_y = r_y[i];
            assign w_z = r_z[i];
            assign w_g = r_g[i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y >= 0) begin
                    r_x[i+1] <= w_x + (w_y >>> i);
                    r_y[i+1] <= w_y - (w_x >>> i);
                    r_z[i+1] <= w_z + gcd_pkg::atan_step(i);
                end else begin
                    r_x[i+1] <= w_x - (w_y >>> i);
                    r_y[i+1] <= w_y + (w_x >>> i);
                    r_z[i+1] <= w_z - gcd_pkg::atan_step(i);
                end
                r_g[i+1] <= w_g;
            end
        end
    end

    always_comb begin
        n_z = r_g[N] ? gcd_pkg::PI_Q29 - r_z[N] : r_z[N];
        if (n_z < 0) begin
            n_z = '0;
        end else if (n_z > gcd_pkg::PI_Q29) begin
            n_z = gcd_pkg::PI_Q29;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_z[30:0];
        end
    end

    assign o_v     = r_ov;
    assign o_angle = r_angle;

endmodule

// ----- rtl/great_circle_distance.sv -----
// ----------------------------------------------------------------------------
// great_circle_distance
// Great-circle distance in meters between two points in signed microdegrees
// ----------------------------------------------------------------------------
// Input channel i_valid / o_ready carries one point pair per request
// (i_lat_a, i_lon_a, i_lat_b, i_lon_b). Output channel o_valid / i_ready
// carries o_distance_m, rounded meters, one result per request, in order.
// The datapath is a single stalling pipeline: three sine/cosine cordic units,
// the product and sum of the spherical law of cosines, a one-bit-per-stage
// square root, a vectoring cordic for the arc angle and the meter scaling.
// Throughput is one request per cycle while o_ready is high. A two-entry
// output queue sits behind the pipeline; while it has a free entry the
// pipeline moves and o_ready stays high, so requests are taken while a
// result waits. When the receiver stalls and the queue fills, the whole
// pipeline holds and o_ready drops, with nothing lost or repeated.
// Synchronous reset clears all valid bits and the queue; no request is
// in flight after reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
module great_circle_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [24:0]        o_distance_m
);

    logic               en;

    logic               r_v0;
    logic signed [29:0] r_lat_a, r_lat_b, r_dlon;

    logic               sa_v, sb_v, sd_v;
    logic signed [31:0] sa, ca, sb, cb, sd, cd;

    logic               r_v1, r_v2, r_v3;
    logic signed [63:0] r_p1, r_p2, r_p3;
    logic signed [31:0] r_cd, r_r1, r_s;
    logic signed [31:0] n_r2;
    logic signed [63:0] n_r3w;
    logic signed [31:0] n_sum;

    logic               r_q1v, r_q2v, r_q3v;
    logic [30:0]        r_as1, r_as2, r_as3;
    logic               r_g1, r_g2, r_g3;
    logic [60:0]        r_sq, r_n;

    logic               rt_v;
    logic [30:0]        rt_root;
    logic [31:0]        rt_tag;

    logic               ac_v;
    logic [30:0]        ac_angle;

    logic               r_e1v, r_e2v;
    logic [61:0]        r_mp;
    logic [61:0]        n_mr;
    logic [24:0]        r_dist;

    logic [1:0]         r_cnt;
    logic [24:0]        r_d0, r_d1;
    logic               push, pop;

    assign en = (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat_a <= 30'(i_lat_a);
            r_lat_b <= 30'(i_lat_b);
            r_dlon  <= 30'(i_lon_a) - 30'(i_lon_b);
        end
    end

    gcd_sincos u_sc_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (r_v0),
        .i_udeg (r_lat_a), .o_v (sa_v), .o_sin (sa), .o_cos (ca)
    );

    gcd_sincos u_sc_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (r_v0),
        .i_udeg (r_lat_b), .o_v (sb_v), .o_sin (sb), .o_cos (cb)
    );

    gcd_sincos u_sc_d (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (r_v0),
        .i_udeg (r_dlon), .o_v (sd_v), .o_sin (sd), .o_cos (cd)
    );

    // law of cosines sum
    assign n_r2  = 32'((r_p2 + gcd_pkg::HALF_Q30) >>> 30);
    assign n_r3w = (r_p3 + gcd_pkg::HALF_Q30) >>> 30;

    always_comb begin
        n_sum = r_r1 + 32'(n_r3w);
        if (n_sum > gcd_pkg::ONE_Q30) begin
            n_sum = gcd_pkg::ONE_Q30;
        end else if (n_sum < -gcd_pkg::ONE_Q30) begin
            n_sum = -gcd_pkg::ONE_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_q1v <= 1'b0;
            r_q2v <= 1'b0;
            r_q3v <= 1'b0;
            r_e1v <= 1'b0;
            r_e2v <= 1'b0;
        end else if (en) begin
            r_v1  <= sa_v & sb_v & sd_v;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_q1v <= r_v3;
            r_q2v <= r_q1v;
            r_q3v <= r_q2v;
            r_e1v <= ac_v;
            r_e2v <= r_e1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1  <= sa * sb;
            r_p2  <= ca * cb;
            r_cd  <= cd;
            r_r1  <= 32'((r_p1 + gcd_pkg::HALF_Q30) >>> 30);
            r_p3  <= n_r2 * r_cd;
            r_s   <= n_sum;
            r_as1 <= (r_s < 0) ? 31'(-r_s) : 31'(r_s);
            r_g1  <= r_s < 0;
            r_sq  <= 61'(r_as1) * 61'(r_as1);
            r_as2 <= r_as1;
            r_g2  <= r_g1;
            r_n   <= gcd_pkg::ONE_Q60 - r_sq;
            r_as3 <= r_as2;
            r_g3  <= r_g2;
        end
    end

    gcd_isqrt u_root (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (r_q3v),
        .i_n (r_n), .i_tag ({r_g3, r_as3}),
        .o_v (rt_v), .o_root (rt_root), .o_tag (rt_tag)
    );

    gcd_acos u_acos (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (rt_v),
        .i_abs_cos (rt_tag[30:0]), .i_root (rt_root), .i_neg (rt_tag[31]),
        .o_v (ac_v), .o_angle (ac_angle)
    );

    // meters from radians
    assign n_mr = r_mp + gcd_pkg::ROUND_METERS;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mp   <= 62'(ac_angle) * 62'(gcd_pkg::METERS_PER_RAD_Q8);
            r_dist <= n_mr[61:37];
        end
    end

    // output queue
    assign push = en & r_e2v;
    assign pop  = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case ({push, pop})
                2'b10: begin
                    if (r_cnt == 2'd0) begin
                        r_d0 <= r_dist;
                    end else begin
                        r_d1 <= r_dist;
                    end
                    r_cnt <= r_cnt + 2'd1;
                end
                2'b01: begin
                    r_d0  <= r_d1;
                    r_cnt <= r_cnt - 2'd1;
                end
                2'b11: begin
                    r_d0 <= r_dist;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ready      = en;
    assign o_valid      = (r_cnt != 2'd0);
    assign o_distance_m = r_d0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid)
        else $error("pushed result not presented");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_dist) && $stable(r_e2v))
        else $error("pipeline moved during stall");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance_m <= 25'd20014125)
        else $error("distance out of range");

endmodule
